[hdl/two_axis_hall_homing_sequencer_macros.svh]
// Assertion helpers used by the checker file.
`ifndef TWO_AXIS_HALL_HOMING_SEQUENCER_MACROS_SVH
`define TWO_AXIS_HALL_HOMING_SEQUENCER_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define THHS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("thhs assertion failed");

// Next-cycle implication, held off while reset is asserted.
`define THHS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("thhs assertion failed");

`endif

[hdl/thhs_pkg.sv]
`timescale 1ns / 1ps

package thhs_pkg;

    // Opcodes carried by each input word
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_LOAD  = 2'd3
    } t_opcode;

    // Status codes shown on the result word
    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_SETTLE  = 3'd1,
        ST_HOMING  = 3'd2,
        ST_DONE    = 3'd3,
        ST_FAIL    = 3'd4,
        ST_TIMEOUT = 3'd5,
        ST_STOPPED = 3'd6
    } t_status;

    // Sequencer phase, one-hot
    typedef enum logic [6:0] {
        PH_IDLE    = 7'b0000001,
        PH_SETTLE  = 7'b0000010,
        PH_HOMING  = 7'b0000100,
        PH_DONE    = 7'b0001000,
        PH_FAIL    = 7'b0010000,
        PH_TIMEOUT = 7'b0100000,
        PH_STOPPED = 7'b1000000
    } t_phase;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_BOWL_THR   = 3'd0,
        CFG_ANGLE_THR  = 3'd1,
        CFG_WINDOW     = 3'd2,
        CFG_UNLOCK     = 3'd3,
        CFG_FWD_SEARCH = 3'd4,
        CFG_BWD_SEARCH = 3'd5,
        CFG_MAX_ITER   = 3'd6,
        CFG_PREMOVE    = 3'd7
    } t_cfg_idx;

    localparam int SAMPLE_W = 10;
    localparam int COUNT_W  = 8;
    localparam int STEPS_W  = 20;
    localparam int PREMOVE_W = 21;
    localparam int POS_W    = 32;
    localparam int CFG_W    = 21;

    // Register reset values
    localparam logic [SAMPLE_W-1:0]  RST_BOWL_THR   = 10'd200;
    localparam logic [SAMPLE_W-1:0]  RST_ANGLE_THR  = 10'd200;
    localparam logic [COUNT_W-1:0]   RST_WINDOW     = 8'd100;
    localparam logic [STEPS_W-1:0]   RST_UNLOCK     = 20'd3000;
    localparam logic [STEPS_W-1:0]   RST_FWD_SEARCH = 20'd1500;
    localparam logic [STEPS_W-1:0]   RST_BWD_SEARCH = 20'd3000;
    localparam logic [STEPS_W-1:0]   RST_MAX_ITER   = 20'd20000;
    localparam logic [PREMOVE_W-1:0] RST_PREMOVE    = 21'h1FFE0C; // -500

    // Saturating 20-bit increment
    function automatic logic [STEPS_W-1:0] inc_sat(input logic [STEPS_W-1:0] v);
        inc_sat = (&v) ? v : v + 20'd1;
    endfunction

    // Phase to status code
    function automatic t_status phase_status(input t_phase ph);
        t_status s;
        unique case (ph)
            PH_IDLE:    s = ST_IDLE;
            PH_SETTLE:  s = ST_SETTLE;
            PH_HOMING:  s = ST_HOMING;
            PH_DONE:    s = ST_DONE;
            PH_FAIL:    s = ST_FAIL;
            PH_TIMEOUT: s = ST_TIMEOUT;
            PH_STOPPED: s = ST_STOPPED;
            default:    s = ST_IDLE;
        endcase
        phase_status = s;
    endfunction

endpackage

[hdl/thhs_qualify.sv]
`timescale 1ns / 1ps

// Hall sensor qualifier: counts consecutive samples at or above threshold,
// saturating at the window, and flags near once the window is reached.
module thhs_qualify (
    input  logic                          i_en,
    input  logic [thhs_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [thhs_pkg::SAMPLE_W-1:0] i_thr,
    input  logic [thhs_pkg::COUNT_W-1:0]  i_window,
    input  logic [thhs_pkg::COUNT_W-1:0]  i_count,
    input  logic                          i_near,
    output logic [thhs_pkg::COUNT_W-1:0]  o_count,
    output logic                          o_near
);
    import thhs_pkg::*;

    logic [COUNT_W-1:0] w_count_up;

    // count cannot wrap past 255 here since it only rises while under the window
    assign w_count_up = (i_count < i_window) ? i_count + 8'd1 : i_count;

    always_comb begin
        o_count = i_count;
        o_near  = i_near;
        if (i_en) begin
            if (i_sample < i_thr) begin
                o_count = '0;
                o_near  = 1'b0;
            end else begin
                o_count = w_count_up;
                o_near  = (w_count_up >= i_window);
            end
        end
    end

endmodule

[hdl/two_axis_hall_homing_sequencer.sv]
`timescale 1ns / 1ps

// Two-axis hall homing sequencer. Each input word is one tick (opcode plus
// two raw hall samples and a position value) and yields exactly one result
// word. A word is taken every clock when the output side keeps up; each word
// passes through the input register and then the result register, with the
// whole tick evaluated in a single pass of compare and counter logic between
// them. Configuration writes are registered and must only be made while no
// tick is in flight.
module two_axis_hall_homing_sequencer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [2:0]                      i_cfg_idx,
    input  logic [thhs_pkg::CFG_W-1:0]      i_cfg_data,
    // input words
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_opcode,
    input  logic [thhs_pkg::SAMPLE_W-1:0]   i_bowl_sample,
    input  logic [thhs_pkg::SAMPLE_W-1:0]   i_angle_sample,
    input  logic signed [thhs_pkg::POS_W-1:0] i_position_value,
    // result words
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_bowl_step,
    output logic                            o_bowl_forward,
    output logic                            o_main_step,
    output logic                            o_main_forward,
    output logic                            o_bowl_power,
    output logic [2:0]                      o_status,
    output logic                            o_bowl_near,
    output logic                            o_angle_near,
    output logic                            o_is_homed,
    output logic signed [thhs_pkg::POS_W-1:0] o_main_position
);
    import thhs_pkg::*;

    // configuration registers
    logic [SAMPLE_W-1:0]  r_bowl_thr, r_angle_thr;
    logic [COUNT_W-1:0]   r_window;
    logic [STEPS_W-1:0]   r_unlock, r_fwd_search, r_bwd_search, r_max_iter;
    logic [PREMOVE_W-1:0] r_premove;

    // input register
    logic                 r_in_valid;
    logic [1:0]           r_op;
    logic [SAMPLE_W-1:0]  r_bs, r_as;
    logic [POS_W-1:0]     r_pv;

    // sequencer state
    logic [COUNT_W-1:0]   r_bowl_count, n_bowl_count, r_angle_count, n_angle_count;
    logic                 r_bowl_near, n_bowl_near, r_angle_near, n_angle_near;
    t_phase               r_phase, n_phase;
    logic [COUNT_W-1:0]   r_settle, n_settle;
    logic                 r_bowl_done, n_bowl_done, r_angle_done, n_angle_done;
    logic                 r_unlocked, n_unlocked, r_premove_done, n_premove_done;
    logic                 r_search_bwd, n_search_bwd;
    logic [STEPS_W-1:0]   r_search_cnt, n_search_cnt, r_bowl_total, n_bowl_total;
    logic [STEPS_W-1:0]   r_iter, n_iter;
    logic [POS_W-1:0]     r_main_pos, n_main_pos;
    logic                 r_homed, n_homed;

    // result register
    logic                 r_out_valid;
    logic                 r_o_bstep, r_o_mstep, r_o_mfwd;
    logic [2:0]           r_o_status;
    logic                 r_o_bnear, r_o_anear, r_o_homed;
    logic [POS_W-1:0]     r_o_pos;

    logic                 w_out_free, w_proc, w_running, w_stop;
    logic                 w_unl, w_bq_en, w_aq_en;
    logic [COUNT_W-1:0]   q_bowl_count, q_angle_count;
    logic                 q_bowl_near, q_angle_near;
    logic                 w_bstep, w_mstep, w_mfwd, w_fail;
    logic                 w_above_premove;

    // handshake
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_proc     = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bowl_thr   <= RST_BOWL_THR;
            r_angle_thr  <= RST_ANGLE_THR;
            r_window     <= RST_WINDOW;
            r_unlock     <= RST_UNLOCK;
            r_fwd_search <= RST_FWD_SEARCH;
            r_bwd_search <= RST_BWD_SEARCH;
            r_max_iter   <= RST_MAX_ITER;
            r_premove    <= RST_PREMOVE;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_BOWL_THR:   r_bowl_thr   <= i_cfg_data[SAMPLE_W-1:0];
                CFG_ANGLE_THR:  r_angle_thr  <= i_cfg_data[SAMPLE_W-1:0];
                CFG_WINDOW:     r_window     <= i_cfg_data[COUNT_W-1:0];
                CFG_UNLOCK:     r_unlock     <= i_cfg_data[STEPS_W-1:0];
                CFG_FWD_SEARCH: r_fwd_search <= i_cfg_data[STEPS_W-1:0];
                CFG_BWD_SEARCH: r_bwd_search <= i_cfg_data[STEPS_W-1:0];
                CFG_MAX_ITER:   r_max_iter   <= i_cfg_data[STEPS_W-1:0];
                CFG_PREMOVE:    r_premove    <= i_cfg_data[PREMOVE_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_op <= i_opcode;
            r_bs <= i_bowl_sample;
            r_as <= i_angle_sample;
            r_pv <= i_position_value;
        end
    end

    // qualifier enables
    assign w_running = (r_phase == PH_SETTLE) || (r_phase == PH_HOMING);
    assign w_stop    = w_running && (t_opcode'(r_op) == OP_STOP);
    assign w_unl     = r_unlocked || (r_bowl_total >= r_unlock) || r_bowl_done;
    assign w_bq_en   = w_proc && !w_stop && !((r_phase == PH_HOMING) && r_bowl_done);
    assign w_aq_en   = w_proc && !w_stop &&
                       !((r_phase == PH_HOMING) &&
                         !(!r_angle_done && w_unl && r_premove_done));

    thhs_qualify u_bowl_q (
        .i_en     (w_bq_en),
        .i_sample (r_bs),
        .i_thr    (r_bowl_thr),
        .i_window (r_window),
        .i_count  (r_bowl_count),
        .i_near   (r_bowl_near),
        .o_count  (q_bowl_count),
        .o_near   (q_bowl_near)
    );

    thhs_qualify u_angle_q (
        .i_en     (w_aq_en),
        .i_sample (r_as),
        .i_thr    (r_angle_thr),
        .i_window (r_window),
        .i_count  (r_angle_count),
        .i_near   (r_angle_near),
        .o_count  (q_angle_count),
        .o_near   (q_angle_near)
    );

    assign w_above_premove = $signed(r_main_pos) >
                             $signed({{(POS_W-PREMOVE_W){r_premove[PREMOVE_W-1]}}, r_premove});

    // one tick of the sequencer
    always_comb begin
        n_bowl_count   = q_bowl_count;
        n_bowl_near    = q_bowl_near;
        n_angle_count  = q_angle_count;
        n_angle_near   = q_angle_near;
        n_phase        = r_phase;
        n_settle       = r_settle;
        n_bowl_done    = r_bowl_done;
        n_angle_done   = r_angle_done;
        n_unlocked     = r_unlocked;
        n_premove_done = r_premove_done;
        n_search_bwd   = r_search_bwd;
        n_search_cnt   = r_search_cnt;
        n_bowl_total   = r_bowl_total;
        n_iter         = r_iter;
        n_main_pos     = r_main_pos;
        n_homed        = r_homed;
        w_bstep        = 1'b0;
        w_mstep        = 1'b0;
        w_mfwd         = 1'b0;
        w_fail         = 1'b0;
        if (w_proc) begin
            if (w_stop) begin
                n_phase = PH_STOPPED;
            end else if (r_phase == PH_SETTLE) begin
                if (r_settle >= r_window) begin
                    n_phase = PH_HOMING;
                end else begin
                    n_settle = r_settle + 8'd1;
                end
            end else if (r_phase == PH_HOMING) begin
                n_unlocked   = w_unl;
                n_bowl_done  = r_bowl_done | q_bowl_near;
                n_angle_done = r_angle_done | (w_unl & r_premove_done & q_angle_near);
                if (!n_bowl_done) begin
                    w_bstep      = 1'b1;
                    n_bowl_total = inc_sat(r_bowl_total);
                end
                // main axis: pre-move, forward search, backward search
                if (!n_angle_done && w_unl) begin
                    if (!r_premove_done) begin
                        if (w_above_premove) begin
                            w_mstep    = 1'b1;
                            n_main_pos = r_main_pos - 32'd1;
                        end else begin
                            n_premove_done = 1'b1;
                        end
                    end else if (!r_search_bwd) begin
                        if (r_search_cnt < r_fwd_search) begin
                            w_mstep      = 1'b1;
                            w_mfwd       = 1'b1;
                            n_main_pos   = r_main_pos + 32'd1;
                            n_search_cnt = inc_sat(r_search_cnt);
                        end else begin
                            n_search_bwd = 1'b1;
                            n_search_cnt = '0;
                        end
                    end else begin
                        if (r_search_cnt < r_bwd_search) begin
                            w_mstep      = 1'b1;
                            n_main_pos   = r_main_pos - 32'd1;
                            n_search_cnt = inc_sat(r_search_cnt);
                        end else begin
                            w_fail = 1'b1;
                        end
                    end
                end
                // run outcome
                if (w_fail) begin
                    n_phase = PH_FAIL;
                end else if (n_angle_done && n_bowl_done) begin
                    n_main_pos = '0;
                    n_homed    = 1'b1;
                    n_phase    = PH_DONE;
                end else begin
                    n_iter = inc_sat(r_iter);
                    if (n_iter >= r_max_iter) begin
                        n_phase = PH_TIMEOUT;
                    end
                end
            end else if (t_opcode'(r_op) == OP_START) begin
                n_bowl_done    = 1'b0;
                n_angle_done   = 1'b0;
                n_unlocked     = 1'b0;
                n_premove_done = 1'b0;
                n_search_bwd   = 1'b0;
                n_search_cnt   = '0;
                n_bowl_total   = '0;
                n_iter         = '0;
                // a zero window skips straight to homing
                if (r_window == '0) begin
                    n_phase  = PH_HOMING;
                    n_settle = '0;
                end else begin
                    n_phase  = PH_SETTLE;
                    n_settle = 8'd1;
                end
            end else if (t_opcode'(r_op) == OP_LOAD) begin
                n_main_pos = r_pv;
            end
        end
    end

    // sequencer state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bowl_count   <= '0;
            r_bowl_near    <= 1'b0;
            r_angle_count  <= '0;
            r_angle_near   <= 1'b0;
            r_phase        <= PH_IDLE;
            r_settle       <= '0;
            r_bowl_done    <= 1'b0;
            r_angle_done   <= 1'b0;
            r_unlocked     <= 1'b0;
            r_premove_done <= 1'b0;
            r_search_bwd   <= 1'b0;
            r_search_cnt   <= '0;
            r_bowl_total   <= '0;
            r_iter         <= '0;
            r_main_pos     <= '0;
            r_homed        <= 1'b0;
        end else begin
            r_bowl_count   <= n_bowl_count;
            r_bowl_near    <= n_bowl_near;
            r_angle_count  <= n_angle_count;
            r_angle_near   <= n_angle_near;
            r_phase        <= n_phase;
            r_settle       <= n_settle;
            r_bowl_done    <= n_bowl_done;
            r_angle_done   <= n_angle_done;
            r_unlocked     <= n_unlocked;
            r_premove_done <= n_premove_done;
            r_search_bwd   <= n_search_bwd;
            r_search_cnt   <= n_search_cnt;
            r_bowl_total   <= n_bowl_total;
            r_iter         <= n_iter;
            r_main_pos     <= n_main_pos;
            r_homed        <= n_homed;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proc) begin
            r_out_valid <= 1'b1;
        end else if (w_out_free) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            r_o_bstep  <= w_bstep;
            r_o_mstep  <= w_mstep;
            r_o_mfwd   <= w_mfwd;
            r_o_status <= phase_status(n_phase);
            r_o_bnear  <= n_bowl_near;
            r_o_anear  <= n_angle_near;
            r_o_homed  <= n_homed;
            r_o_pos    <= n_main_pos;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_bowl_step     = r_o_bstep;
    assign o_bowl_forward  = 1'b0;
    assign o_main_step     = r_o_mstep;
    assign o_main_forward  = r_o_mfwd;
    assign o_bowl_power    = r_o_bstep;
    assign o_status        = r_o_status;
    assign o_bowl_near     = r_o_bnear;
    assign o_angle_near    = r_o_anear;
    assign o_is_homed      = r_o_homed;
    assign o_main_position = r_o_pos;

endmodule

[hdl/thhs_checker.sv]
`timescale 1ns / 1ps

`include "two_axis_hall_homing_sequencer_macros.svh"

// Port-level checks on the result word stream.
module thhs_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic                            o_bowl_step,
    input logic                            o_bowl_forward,
    input logic                            o_main_step,
    input logic                            o_main_forward,
    input logic                            o_bowl_power,
    input logic [2:0]                      o_status,
    input logic                            o_is_homed,
    input logic signed [thhs_pkg::POS_W-1:0] o_main_position
);
    import thhs_pkg::*;

    // bowl relay follows the bowl step, and the bowl only runs backward
    `THHS_ASSERT_NOW(a_bowl_power, i_clk, i_rst_n, o_out_valid, (o_bowl_power == o_bowl_step) && !o_bowl_forward)

    // a forward main direction only comes with a main step
    `THHS_ASSERT_NOW(a_main_fwd, i_clk, i_rst_n, o_out_valid && o_main_forward, o_main_step)

    // a finished run reports homed; later loads may move the position
    `THHS_ASSERT_NOW(a_done_homed, i_clk, i_rst_n, o_out_valid && (o_status == ST_DONE), o_is_homed)

    // a stalled result word holds
    `THHS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_status) && $stable(o_main_position))

endmodule

bind two_axis_hall_homing_sequencer thhs_checker u_thhs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_bowl_step     (o_bowl_step),
    .o_bowl_forward  (o_bowl_forward),
    .o_main_step     (o_main_step),
    .o_main_forward  (o_main_forward),
    .o_bowl_power    (o_bowl_power),
    .o_status        (o_status),
    .o_is_homed      (o_is_homed),
    .o_main_position (o_main_position)
);

[verif/tb_two_axis_hall_homing_sequencer.sv]
`timescale 1ns / 1ps

module tb_two_axis_hall_homing_sequencer;
    import thhs_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 4000;
    localparam int WORD_TARGET  = 1800;
    localparam int RUN_TICK_CAP = 600;

    // Receiver stall patterns
    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    // One expected result word
    typedef struct packed {
        logic        bowl_step;
        logic        bowl_forward;
        logic        main_step;
        logic        main_forward;
        logic        bowl_power;
        t_status     status;
        logic        bowl_near;
        logic        angle_near;
        logic        is_homed;
        logic [31:0] main_position;
    } t_tick_result;

    // DUT ports
    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [2:0]                 i_cfg_idx = '0;
    logic [CFG_W-1:0]           i_cfg_data = '0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic [1:0]                 i_opcode = '0;
    logic [SAMPLE_W-1:0]        i_bowl_sample = '0;
    logic [SAMPLE_W-1:0]        i_angle_sample = '0;
    logic signed [POS_W-1:0]    i_position_value = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic                       o_bowl_step;
    logic                       o_bowl_forward;
    logic                       o_main_step;
    logic                       o_main_forward;
    logic                       o_bowl_power;
    logic [2:0]                 o_status;
    logic                       o_bowl_near;
    logic                       o_angle_near;
    logic                       o_is_homed;
    logic signed [POS_W-1:0]    o_main_position;

    // Predicted configuration
    logic [9:0]         cfg_bowl_thr;
    logic [9:0]         cfg_angle_thr;
    logic [7:0]         cfg_window;
    logic [19:0]        cfg_unlock;
    logic [19:0]        cfg_fwd_len;
    logic [19:0]        cfg_bwd_len;
    logic [19:0]        cfg_max_iter;
    logic signed [20:0] cfg_premove;

    // Predicted sequencer state
    logic [7:0]         bowl_qual_cnt;
    logic [7:0]         angle_qual_cnt;
    logic [7:0]         settle_ticks;
    logic               bowl_is_near;
    logic               angle_is_near;
    t_status            seq_status;
    logic               bowl_homed;
    logic               angle_found;
    logic               main_free;
    logic               premove_reached;
    logic               searching_back;
    logic [19:0]        search_steps;
    logic [19:0]        bowl_steps;
    logic [19:0]        iter_ticks;
    logic signed [31:0] main_pos_pred;
    logic               homed_seen;

    t_tick_result pending_results[$];
    t_tick_result want_res;
    int           mismatches = 0;
    int           words_sent = 0;
    int           burst_left = 0;
    bit           sender_flat = 1'b0;
    bit           hold_req = 1'b0;
    int           hold_left = 0;
    int           mode_left = 0;
    int           stall_phase = 0;
    t_stall_mode  stall_mode = STALL_NONE;
    int           quiet_cycles = 0;

    two_axis_hall_homing_sequencer u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_bowl_sample    (i_bowl_sample),
        .i_angle_sample   (i_angle_sample),
        .i_position_value (i_position_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_bowl_step      (o_bowl_step),
        .o_bowl_forward   (o_bowl_forward),
        .o_main_step      (o_main_step),
        .o_main_forward   (o_main_forward),
        .o_bowl_power     (o_bowl_power),
        .o_status         (o_status),
        .o_bowl_near      (o_bowl_near),
        .o_angle_near     (o_angle_near),
        .o_is_homed       (o_is_homed),
        .o_main_position  (o_main_position)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [19:0] bump20(input logic [19:0] v);
        return (v == 20'hFFFFF) ? v : v + 20'd1;
    endfunction

    task automatic init_model();
        cfg_bowl_thr    = 10'd200;
        cfg_angle_thr   = 10'd200;
        cfg_window      = 8'd100;
        cfg_unlock      = 20'd3000;
        cfg_fwd_len     = 20'd1500;
        cfg_bwd_len     = 20'd3000;
        cfg_max_iter    = 20'd20000;
        cfg_premove     = -21'sd500;
        bowl_qual_cnt   = '0;
        angle_qual_cnt  = '0;
        settle_ticks    = '0;
        bowl_is_near    = 1'b0;
        angle_is_near   = 1'b0;
        seq_status      = ST_IDLE;
        bowl_homed      = 1'b0;
        angle_found     = 1'b0;
        main_free       = 1'b0;
        premove_reached = 1'b0;
        searching_back  = 1'b0;
        search_steps    = '0;
        bowl_steps      = '0;
        iter_ticks      = '0;
        main_pos_pred   = '0;
        homed_seen      = 1'b0;
    endtask

    // Sensor qualifier: far sample clears, otherwise count up to the window
    task automatic qualify_sample(input logic [9:0] sample, input logic [9:0] thr,
                                  inout logic [7:0] cnt, inout logic near);
        if (sample < thr) begin
            cnt  = '0;
            near = 1'b0;
        end else begin
            if (cnt < cfg_window) cnt = cnt + 8'd1;
            near = (cnt >= cfg_window);
        end
    endtask

    // One homing-phase tick
    task automatic advance_homing(input logic [9:0] bowl_s, input logic [9:0] angle_s,
                                  output logic bstep, output logic mstep,
                                  output logic mfwd);
        bstep = 1'b0;
        mstep = 1'b0;
        mfwd  = 1'b0;
        if (!main_free && (bowl_steps >= cfg_unlock || bowl_homed)) main_free = 1'b1;

        if (!bowl_homed) qualify_sample(bowl_s, cfg_bowl_thr, bowl_qual_cnt, bowl_is_near);
        if (!angle_found && main_free && premove_reached)
            qualify_sample(angle_s, cfg_angle_thr, angle_qual_cnt, angle_is_near);

        if (!bowl_homed && bowl_is_near) bowl_homed = 1'b1;
        if (!angle_found && main_free && premove_reached && angle_is_near)
            angle_found = 1'b1;

        if (!bowl_homed) begin
            bstep = 1'b1;
            bowl_steps = bump20(bowl_steps);
        end

        // main axis: pre-move, forward search, backward search
        if (!angle_found && main_free) begin
            if (!premove_reached) begin
                if (main_pos_pred > cfg_premove) begin
                    mstep = 1'b1;
                    main_pos_pred = main_pos_pred - 32'sd1;
                end else begin
                    premove_reached = 1'b1;
                end
            end else if (!searching_back) begin
                if (search_steps < cfg_fwd_len) begin
                    mstep = 1'b1;
                    mfwd  = 1'b1;
                    main_pos_pred = main_pos_pred + 32'sd1;
                    search_steps = bump20(search_steps);
                end else begin
                    searching_back = 1'b1;
                    search_steps   = '0;
                end
            end else begin
                if (search_steps < cfg_bwd_len) begin
                    mstep = 1'b1;
                    main_pos_pred = main_pos_pred - 32'sd1;
                    search_steps = bump20(search_steps);
                end else begin
                    seq_status = ST_FAIL;
                    return;
                end
            end
        end

        if (angle_found && bowl_homed) begin
            main_pos_pred = '0;
            homed_seen    = 1'b1;
            seq_status    = ST_DONE;
            return;
        end

        iter_ticks = bump20(iter_ticks);
        if (iter_ticks >= cfg_max_iter) seq_status = ST_TIMEOUT;
    endtask

    // Work out the result word of one accepted input word
    task automatic predict_tick(input t_opcode op, input logic [9:0] bowl_s,
                                input logic [9:0] angle_s, input logic [31:0] pv);
        t_tick_result r;
        logic bstep, mstep, mfwd, running;
        bstep = 1'b0;
        mstep = 1'b0;
        mfwd  = 1'b0;
        running = (seq_status == ST_SETTLE || seq_status == ST_HOMING);

        if (running && op == OP_STOP) begin
            seq_status = ST_STOPPED;
        end else if (running) begin
            if (seq_status == ST_SETTLE) begin
                qualify_sample(bowl_s, cfg_bowl_thr, bowl_qual_cnt, bowl_is_near);
                qualify_sample(angle_s, cfg_angle_thr, angle_qual_cnt, angle_is_near);
                if (settle_ticks >= cfg_window) seq_status = ST_HOMING;
                else settle_ticks = settle_ticks + 8'd1;
            end else begin
                advance_homing(bowl_s, angle_s, bstep, mstep, mfwd);
            end
        end else if (op == OP_START) begin
            // run counters cleared, qualifiers and homed flag kept
            bowl_homed      = 1'b0;
            angle_found     = 1'b0;
            main_free       = 1'b0;
            premove_reached = 1'b0;
            searching_back  = 1'b0;
            search_steps    = '0;
            bowl_steps      = '0;
            iter_ticks      = '0;
            settle_ticks    = '0;
            seq_status      = ST_SETTLE;
            qualify_sample(bowl_s, cfg_bowl_thr, bowl_qual_cnt, bowl_is_near);
            qualify_sample(angle_s, cfg_angle_thr, angle_qual_cnt, angle_is_near);
            if (settle_ticks >= cfg_window) seq_status = ST_HOMING;
            else settle_ticks = 8'd1;
        end else begin
            if (op == OP_LOAD) main_pos_pred = pv;
            qualify_sample(bowl_s, cfg_bowl_thr, bowl_qual_cnt, bowl_is_near);
            qualify_sample(angle_s, cfg_angle_thr, angle_qual_cnt, angle_is_near);
        end

        r.bowl_step     = bstep;
        r.bowl_forward  = 1'b0;
        r.main_step     = mstep;
        r.main_forward  = mfwd;
        r.bowl_power    = bstep;
        r.status        = seq_status;
        r.bowl_near     = bowl_is_near;
        r.angle_near    = angle_is_near;
        r.is_homed      = homed_seen;
        r.main_position = main_pos_pred;
        pending_results.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Send one input word; bursts with random gaps unless held flat
    task automatic offer_tick(input t_opcode op, input logic [9:0] bowl_s,
                              input logic [9:0] angle_s, input logic [31:0] pv);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
            if (sender_flat) gap = 0;
            if (gap != 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid       <= 1'b1;
        i_opcode         <= op;
        i_bowl_sample    <= bowl_s;
        i_angle_sample   <= angle_s;
        i_position_value <= pv;
        do @(posedge i_clk); while (o_in_stall);
        predict_tick(op, bowl_s, angle_s, pv);
        words_sent++;
    endtask

    // Stop sending and wait for every expected word, plus pipeline slack
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [20:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_BOWL_THR:   cfg_bowl_thr  = value[9:0];
            CFG_ANGLE_THR:  cfg_angle_thr = value[9:0];
            CFG_WINDOW:     cfg_window    = value[7:0];
            CFG_UNLOCK:     cfg_unlock    = value[19:0];
            CFG_FWD_SEARCH: cfg_fwd_len   = value[19:0];
            CFG_BWD_SEARCH: cfg_bwd_len   = value[19:0];
            CFG_MAX_ITER:   cfg_max_iter  = value[19:0];
            CFG_PREMOVE:    cfg_premove   = value;
        endcase
    endtask

    task automatic program_config(input logic [9:0] bthr, input logic [9:0] athr,
                                  input logic [7:0] win, input logic [19:0] unl,
                                  input logic [19:0] fwd, input logic [19:0] bwd,
                                  input logic [19:0] mi, input logic [20:0] pm);
        write_reg(CFG_BOWL_THR, {11'd0, bthr});
        write_reg(CFG_ANGLE_THR, {11'd0, athr});
        write_reg(CFG_WINDOW, {13'd0, win});
        write_reg(CFG_UNLOCK, {1'b0, unl});
        write_reg(CFG_FWD_SEARCH, {1'b0, fwd});
        write_reg(CFG_BWD_SEARCH, {1'b0, bwd});
        write_reg(CFG_MAX_ITER, {1'b0, mi});
        write_reg(CFG_PREMOVE, pm);
    endtask

    // Sample that reads near or far against a threshold
    function automatic logic [9:0] pick_sample(input logic [9:0] thr, input logic near);
        if (near) return 10'($urandom_range(thr, 1023));
        if (thr == 0) return 10'($urandom_range(0, 1023));
        return 10'($urandom_range(0, thr - 1));
    endfunction

    function automatic logic [9:0] pick_thr();
        case ($urandom_range(0, 7))
            0:       return 10'd0;
            1:       return 10'd1023;
            default: return 10'($urandom_range(50, 900));
        endcase
    endfunction

    // A well-formed homing run: optional load, start, then ticks until it ends
    task automatic run_homing(input int tick_cap);
        int bowl_at, angle_at, n, r;
        t_opcode op;
        logic bn, an;
        logic signed [31:0] start_pos;
        bowl_at  = $urandom_range(0, 25);
        angle_at = $urandom_range(0, 40);
        r = $urandom_range(0, 7);
        if (r == 0) begin
            offer_tick(OP_LOAD, 10'($urandom), 10'($urandom), $urandom);
        end else if (r != 1) begin
            start_pos = 32'(cfg_premove);
            start_pos = start_pos + $urandom_range(0, 12);
            offer_tick(OP_LOAD, 10'($urandom), 10'($urandom), start_pos);
        end
        offer_tick(OP_START, pick_sample(cfg_bowl_thr, bowl_at == 0),
                   pick_sample(cfg_angle_thr, angle_at == 0), $urandom);
        n = 1;
        while ((seq_status == ST_SETTLE || seq_status == ST_HOMING) && n < tick_cap) begin
            r = $urandom_range(0, 199);
            if (r < 4) op = OP_START;
            else if (r < 8) op = OP_LOAD;
            else if (r == 8) op = OP_STOP;
            else op = OP_TICK;
            bn = (n >= bowl_at);
            an = (n >= angle_at);
            // occasional glitch only where the window is short enough to recover
            if (cfg_window <= 8 && $urandom_range(0, 19) == 0) bn = !bn;
            if (cfg_window <= 8 && $urandom_range(0, 19) == 0) an = !an;
            offer_tick(op, pick_sample(cfg_bowl_thr, bn), pick_sample(cfg_angle_thr, an),
                       $urandom);
            n++;
        end
        if (seq_status == ST_SETTLE || seq_status == ST_HOMING)
            offer_tick(OP_STOP, 10'($urandom), 10'($urandom), $urandom);
    endtask

    task automatic send_noise(input int count);
        repeat (count) offer_tick(t_opcode'($urandom_range(0, 3)), 10'($urandom),
                                  10'($urandom), $urandom);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Idle ticks at reset settings: field extremes, tick, load and stop opcodes outside a run
    task automatic test_idle_ticks();
        offer_tick(OP_TICK, 10'd0, 10'd1023, 32'h0000_0000);
        offer_tick(OP_TICK, 10'd1023, 10'd0, 32'hFFFF_FFFF);
        offer_tick(OP_LOAD, 10'd199, 10'd200, 32'h7FFF_FFFF);
        offer_tick(OP_LOAD, 10'd200, 10'd199, 32'h8000_0000);
        offer_tick(OP_STOP, 10'd1023, 10'd1023, 32'h5555_5555);
        offer_tick(OP_LOAD, 10'h2AA, 10'h155, 32'hAAAA_AAAA);
        offer_tick(OP_TICK, 10'h155, 10'h2AA, 32'h0000_0000);
        offer_tick(OP_LOAD, 10'd1023, 10'd1023, 32'hFFFF_FFFF);
    endtask

    // Short runs with window zero: done, stop, search fail, timeout, wrap
    task automatic test_directed_runs();
        drain_results();
        program_config(10'd100, 10'd100, 8'd0, 20'd0, 20'd1, 20'd1, 20'd5, 21'd0);
        // done; a load inside a run is a plain tick
        offer_tick(OP_LOAD, 10'd0, 10'd0, 32'd0);
        offer_tick(OP_START, 10'd1023, 10'd0, 32'd0);
        offer_tick(OP_TICK, 10'd1023, 10'd1023, 32'd0);
        offer_tick(OP_LOAD, 10'd1023, 10'd1023, 32'h1234_5678);
        // stop while homing after a start inside the run (a plain tick), then stop while stopped
        offer_tick(OP_START, 10'd0, 10'd0, 32'd0);
        offer_tick(OP_START, 10'd0, 10'd0, 32'd0);
        offer_tick(OP_STOP, 10'd0, 10'd0, 32'd0);
        offer_tick(OP_STOP, 10'd1023, 10'd1023, 32'd0);
        // search exhausted forward then backward
        offer_tick(OP_START, 10'd1023, 10'd0, 32'd0);
        repeat (5) offer_tick(OP_TICK, 10'd1023, 10'd0, 32'd0);
        // max iterations of zero behaves as one
        drain_results();
        write_reg(CFG_MAX_ITER, 21'd0);
        offer_tick(OP_START, 10'd0, 10'd0, 32'd0);
        offer_tick(OP_TICK, 10'd0, 10'd0, 32'd0);
        // backward search wraps the position through the most negative value
        drain_results();
        write_reg(CFG_MAX_ITER, 21'd50);
        write_reg(CFG_FWD_SEARCH, 21'd0);
        write_reg(CFG_BWD_SEARCH, 21'd4);
        offer_tick(OP_LOAD, 10'd0, 10'd0, 32'h8000_0001);
        offer_tick(OP_START, 10'd0, 10'd0, 32'd0);
        repeat (7) offer_tick(OP_TICK, 10'd0, 10'd0, 32'd0);
    endtask

    // Receiver holds off long while the sender keeps offering words
    task automatic test_backpressure();
        drain_results();
        program_config(10'd150, 10'd150, 8'd2, 20'd5, 20'd6, 20'd8, 20'd80, -21'sd4);
        sender_flat = 1'b1;
        hold_req    = 1'b1;
        send_noise(40);
        run_homing(RUN_TICK_CAP);
        sender_flat = 1'b0;
        drain_results();
    endtask

    // Fixed then random settings per phase; one well-formed run in phase 0, several later, plus noise
    task automatic test_random_runs();
        int phase_idx, runs;
        logic [7:0] win;
        logic [19:0] unl, mi;
        logic [20:0] pm;
        phase_idx = 0;
        while (words_sent < WORD_TARGET) begin
            drain_results();
            case (phase_idx)
                0: program_config(10'd0, 10'd1023, 8'd254, 20'hFFFFF, 20'd2, 20'd5,
                                  20'hFFFFF, 21'h100000);
                1: program_config(10'd1023, 10'd0, 8'd1, 20'd0, 20'hFFFFF, 20'hFFFFF,
                                  20'hFFFFF, 21'd0);
                default: begin
                    win = ($urandom_range(0, 11) == 0) ? 8'd0 : 8'($urandom_range(1, 6));
                    unl = ($urandom_range(0, 9) == 0) ? 20'hFFFFF
                                                      : 20'($urandom_range(0, 20));
                    mi  = ($urandom_range(0, 9) == 0 || phase_idx == 2) ? 20'd1
                                                      : 20'($urandom_range(10, 120));
                    pm  = ($urandom_range(0, 9) == 0) ? 21'h100000
                                                     : -$signed(21'($urandom_range(0, 10)));
                    program_config(pick_thr(), pick_thr(), win, unl,
                                   20'($urandom_range(0, 15)),
                                   20'($urandom_range(0, 20)), mi, pm);
                end
            endcase
            runs = (phase_idx == 0) ? 1 : $urandom_range(3, 6);
            repeat (runs) begin
                run_homing(RUN_TICK_CAP);
                send_noise($urandom_range(0, 3));
            end
            phase_idx++;
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver stall, result checking, watchdog
    // ------------------------------------------------------------------

    // Stall pattern changes every so often; a hold request forces a long stall
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                mode_left  = $urandom_range(20, 200);
            end
            mode_left--;
            stall_phase = (stall_phase + 1) % 7;
            case (stall_mode)
                STALL_NONE:     i_out_stall <= 1'b0;
                STALL_LIGHT:    i_out_stall <= ($urandom_range(0, 4) == 0);
                STALL_HEAVY:    i_out_stall <= ($urandom_range(0, 3) != 0);
                STALL_PERIODIC: i_out_stall <= (stall_phase < 3);
            endcase
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    // Compare each accepted result word with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result word with no prediction waiting");
                mismatches++;
            end else begin
                want_res = pending_results.pop_front();
                check_field("bowl_step", 32'(want_res.bowl_step), 32'(o_bowl_step));
                check_field("bowl_forward", 32'(want_res.bowl_forward),
                            32'(o_bowl_forward));
                check_field("main_step", 32'(want_res.main_step), 32'(o_main_step));
                check_field("main_forward", 32'(want_res.main_forward),
                            32'(o_main_forward));
                check_field("bowl_power", 32'(want_res.bowl_power), 32'(o_bowl_power));
                check_field("status", 32'(want_res.status), 32'(o_status));
                check_field("bowl_near", 32'(want_res.bowl_near), 32'(o_bowl_near));
                check_field("angle_near", 32'(want_res.angle_near), 32'(o_angle_near));
                check_field("is_homed", 32'(want_res.is_homed), 32'(o_is_homed));
                check_field("main_position", want_res.main_position, o_main_position);
            end
        end
    end

    // No word moving on either side for too long ends the run
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        init_model();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_idle_ticks();
        test_directed_runs();
        test_backpressure();
        test_random_runs();
        drain_results();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
